FILE: rtl/deq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue.
// Holds the request and response payloads, operation codes, controller states and commands.
// Depends on nothing.
package deq_pkg;

  localparam int DEFAULT_DEPTH     = 16;
  localparam int DEFAULT_WORD_BITS = 64;
  localparam int FUNC_BITS         = 3;
  localparam int FIELD_WORD_BITS   = 64;
  localparam int OCC_BITS          = 5;

  localparam logic [FUNC_BITS-1:0] FN_PUSH_BACK  = 3'd0;
  localparam logic [FUNC_BITS-1:0] FN_PUSH_FRONT = 3'd1;
  localparam logic [FUNC_BITS-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_BITS-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_BITS-1:0] FN_REVERSE    = 3'd4;
  localparam logic [FUNC_BITS-1:0] FN_QUERY      = 3'd5;

  typedef struct packed {
    logic [FUNC_BITS-1:0]       func;
    logic [FIELD_WORD_BITS-1:0] data_word;
  } req_t;

  typedef struct packed {
    logic [FIELD_WORD_BITS-1:0] front_word;
    logic [FIELD_WORD_BITS-1:0] back_word;
    logic [OCC_BITS-1:0]        occupancy;
    logic                       is_empty;
    logic                       op_error;
  } resp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic read;
  } ctrl_cmd_t;

endpackage

FILE: rtl/deq_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the double-ended queue.
// Sequences capture, update, memory read and response; depends on deq_pkg.
module deq_ctrl
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  output logic      resp_valid,
  input  logic      resp_stall,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!resp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall   = 1'b1;
    resp_valid  = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    cmd.read    = 1'b0;
    case (state)
      ST_IDLE: begin
        req_stall   = 1'b0;
        cmd.capture = req_valid;
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
      end
      ST_READ: begin
        cmd.read = 1'b1;
      end
      ST_DONE: begin
        resp_valid = 1'b1;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  a_resp_blocks_req: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> req_stall)
    else $error("request taken while a response is pending");

  a_capture_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.execute)
    else $error("captured request was not executed next");

  a_exec_then_read: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> cmd.read)
    else $error("update was not followed by a memory read");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.execute, cmd.read}))
    else $error("more than one datapath command at once");

endmodule

FILE: rtl/deq_datapath.sv
`timescale 1ns / 1ps
// Datapath of the double-ended queue: ring store, head pointer, count and direction flag.
// Driven by commands from deq_ctrl; depends on deq_pkg.
module deq_datapath
  import deq_pkg::*;
#(
  parameter int DEPTH     = DEFAULT_DEPTH,
  parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  ctrl_cmd_t cmd,
  input  req_t      req,
  output resp_t     resp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

  logic [WORD_BITS-1:0] mem [DEPTH];

  logic [FUNC_BITS-1:0] func_q;
  logic [WORD_BITS-1:0] word_q;
  logic [AW-1:0]        head;
  logic [AW-1:0]        head_next;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic                 rev;
  logic                 rev_next;
  logic                 err;
  logic                 err_next;
  logic [WORD_BITS-1:0] lo_data;
  logic [WORD_BITS-1:0] hi_data;

  logic          full;
  logic          empty;
  logic          push_lo;
  logic          push_hi;
  logic          pop_lo;
  logic          pop_hi;
  logic          flip;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail_slot;
  logic [AW:0]   hi_sum;
  logic [AW-1:0] hi_slot;
  logic [AW-1:0] wr_addr;

  assign full  = (count == DEPTH_C);
  assign empty = (count == '0);

  always_comb begin
    push_lo  = 1'b0;
    push_hi  = 1'b0;
    pop_lo   = 1'b0;
    pop_hi   = 1'b0;
    flip     = 1'b0;
    err_next = 1'b0;
    case (func_q)
      FN_PUSH_BACK: begin
        if (full) err_next = 1'b1;
        else if (rev) push_lo = 1'b1;
        else push_hi = 1'b1;
      end
      FN_PUSH_FRONT: begin
        if (full) err_next = 1'b1;
        else if (rev) push_hi = 1'b1;
        else push_lo = 1'b1;
      end
      FN_POP_FRONT: begin
        if (empty) err_next = 1'b1;
        else if (rev) pop_hi = 1'b1;
        else pop_lo = 1'b1;
      end
      FN_POP_BACK: begin
        if (empty) err_next = 1'b1;
        else if (rev) pop_lo = 1'b1;
        else pop_hi = 1'b1;
      end
      FN_REVERSE: begin
        if (empty) err_next = 1'b1;
        else flip = 1'b1;
      end
      default: begin
        err_next = 1'b0;
      end
    endcase
  end

  assign head_dec  = (head == '0) ? LAST_SLOT : head - AW'(1);
  assign head_inc  = (head == LAST_SLOT) ? '0 : head + AW'(1);
  assign tail_sum  = {1'b0, head} + (AW + 1)'(count);
  assign tail_slot = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);
  assign wr_addr   = push_lo ? head_dec : tail_slot;

  // The highest live entry sits count - 1 slots above the head, modulo the depth.
  assign hi_sum  = empty ? {1'b0, head} : tail_sum - (AW + 1)'(1);
  assign hi_slot = (hi_sum >= DEPTH_W) ? AW'(hi_sum - DEPTH_W) : AW'(hi_sum);

  always_comb begin
    head_next  = head;
    count_next = count;
    rev_next   = rev ^ flip;
    if (push_lo) begin
      head_next  = head_dec;
      count_next = count + CW'(1);
    end else if (push_hi) begin
      count_next = count + CW'(1);
    end else if (pop_lo) begin
      head_next  = head_inc;
      count_next = count - CW'(1);
    end else if (pop_hi) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      rev   <= 1'b0;
    end else if (cmd.execute) begin
      head  <= head_next;
      count <= count_next;
      rev   <= rev_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= req.func;
      word_q <= req.data_word[WORD_BITS-1:0];
    end
    if (cmd.execute) begin
      err <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && (push_lo || push_hi)) begin
      mem[wr_addr] <= word_q;
    end
    if (cmd.read) begin
      lo_data <= mem[head];
      hi_data <= mem[hi_slot];
    end
  end

  always_comb begin
    resp.front_word = '0;
    resp.back_word  = '0;
    if (!empty) begin
      resp.front_word = rev ? FIELD_WORD_BITS'(hi_data) : FIELD_WORD_BITS'(lo_data);
      resp.back_word  = rev ? FIELD_WORD_BITS'(lo_data) : FIELD_WORD_BITS'(hi_data);
    end
    resp.occupancy = OCC_BITS'(count);
    resp.is_empty  = empty;
    resp.op_error  = err;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count beyond the depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= LAST_SLOT)
    else $error("head pointer outside the ring");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(cmd.execute)) |-> ($stable(count) && $stable(head) && $stable(rev)))
    else $error("queue state changed outside an update");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && full) |-> !(push_lo || push_hi))
    else $error("push into a full queue was stored");

endmodule

FILE: rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// Top level of the double-ended queue: controller plus datapath.
// Depends on deq_pkg, deq_ctrl and deq_datapath.
// Each request carries one operation (push back, push front, pop front, pop back, reverse,
// or query) and yields exactly one response with the front and back words, the occupancy,
// an empty flag and an error flag. Requests are handled one at a time: the next request is
// taken in the cycle after the previous response is accepted. Each request passes through
// the controller sequence of capture, pointer update with store write, registered store
// read at both ends, and response. Pushes into a full queue are dropped and flagged; pops
// and reversals of an empty queue are flagged and change nothing. After reset the queue is
// empty and ready at once.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH     = DEFAULT_DEPTH,
  parameter int WORD_BITS = DEFAULT_WORD_BITS
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  req_t  req,
  output logic  resp_valid,
  input  logic  resp_stall,
  output resp_t resp
);

  ctrl_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .cmd        (cmd)
  );

  deq_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (req),
    .resp (resp)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the double-ended queue, with a directed table and random traffic.
// Uses deq_pkg and double_ended_queue; an internal ring model predicts all unpinned responses.
module tb_top
  import deq_pkg::*;
();

  localparam int DEPTH = DEFAULT_DEPTH;
  localparam int DIRECTED_ROWS = 20;
  localparam int RANDOM_REQUESTS = 1100;
  localparam logic [FUNC_BITS-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_BITS-1:0] FN_SPARE_7 = 3'd7;
  localparam logic [63:0] ALL_ONES = {64{1'b1}};
  localparam resp_t EMPTY_OK = '{64'd0, 64'd0, 5'd0, 1'b1, 1'b0};
  localparam resp_t EMPTY_ERR = '{64'd0, 64'd0, 5'd0, 1'b1, 1'b1};

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic [63:0]          word;
    logic [7:0]           reps;
    logic                 pinned;
    resp_t                want;
  } plan_row_t;

  logic  clk;
  logic  rst;
  logic  req_valid;
  logic  req_stall;
  req_t  req;
  logic  resp_valid;
  logic  resp_stall;
  resp_t resp;

  logic [63:0] ring_words [DEPTH];
  logic [3:0]  ring_head;
  logic [4:0]  ring_count;
  logic        ring_flipped;

  resp_t     pending_status_q [$];
  plan_row_t plan [DIRECTED_ROWS];
  int        fail_count;
  int        burst_left;

  double_ended_queue dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .resp_valid(resp_valid),
    .resp_stall(resp_stall),
    .resp      (resp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic resp_t deque_apply(req_t r);
    resp_t      s;
    logic [3:0] slot;
    logic       err;
    err = 1'b0;
    case (r.func)
      FN_PUSH_BACK, FN_PUSH_FRONT: begin
        if (ring_count >= DEPTH) begin
          err = 1'b1;
        end else if ((r.func == FN_PUSH_BACK) != ring_flipped) begin
          slot = ring_head + ring_count[3:0];
          ring_words[slot] = r.data_word;
          ring_count = ring_count + 5'd1;
        end else begin
          ring_head = ring_head - 4'd1;
          ring_words[ring_head] = r.data_word;
          ring_count = ring_count + 5'd1;
        end
      end
      FN_POP_FRONT, FN_POP_BACK: begin
        if (ring_count == 0) begin
          err = 1'b1;
        end else if ((r.func == FN_POP_FRONT) != ring_flipped) begin
          ring_head = ring_head + 4'd1;
          ring_count = ring_count - 5'd1;
        end else begin
          ring_count = ring_count - 5'd1;
        end
      end
      FN_REVERSE: begin
        if (ring_count == 0) begin
          err = 1'b1;
        end else begin
          ring_flipped = !ring_flipped;
        end
      end
      default: begin
      end
    endcase
    s = '0;
    if (ring_count != 0) begin
      slot = ring_head + ring_count[3:0] - 4'd1;
      s.front_word = ring_flipped ? ring_words[slot] : ring_words[ring_head];
      s.back_word = ring_flipped ? ring_words[ring_head] : ring_words[slot];
    end
    s.occupancy = ring_count;
    s.is_empty = (ring_count == 0);
    s.op_error = err;
    return s;
  endfunction

  // Holds one request until the queue takes it, then records the response it must produce.
  task automatic issue(input req_t r, input logic pinned, input resp_t pinned_resp);
    resp_t s;
    int    gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    s = deque_apply(r);
    pending_status_q.push_back(pinned ? pinned_resp : s);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : resp_monitor
    resp_t want;
    if (!rst && resp_valid && !resp_stall) begin
      if (pending_status_q.size() == 0) begin
        $display("%0t: unexpected response %h", $time, resp);
        fail_count++;
      end else begin
        want = pending_status_q.pop_front();
        if (resp.front_word !== want.front_word) begin
          $display("%0t: front_word expected %h, got %h", $time, want.front_word,
                   resp.front_word);
          fail_count++;
        end
        if (resp.back_word !== want.back_word) begin
          $display("%0t: back_word expected %h, got %h", $time, want.back_word,
                   resp.back_word);
          fail_count++;
        end
        if (resp.occupancy !== want.occupancy) begin
          $display("%0t: occupancy expected %0d, got %0d", $time, want.occupancy,
                   resp.occupancy);
          fail_count++;
        end
        if (resp.is_empty !== want.is_empty) begin
          $display("%0t: is_empty expected %b, got %b", $time, want.is_empty, resp.is_empty);
          fail_count++;
        end
        if (resp.op_error !== want.op_error) begin
          $display("%0t: op_error expected %b, got %b", $time, want.op_error, resp.op_error);
          fail_count++;
        end
      end
    end
  end

  // The receiver stalls at a duty that changes from stretch to stretch, and holds off
  // completely for a long stretch once so that the request side backs up.
  initial begin : resp_side
    int cycle_n;
    int phase_left;
    int duty;
    cycle_n = 0;
    phase_left = 0;
    duty = 0;
    resp_stall = 1'b0;
    forever begin
      @(negedge clk);
      cycle_n++;
      if (cycle_n >= 1500 && cycle_n < 1650) begin
        resp_stall <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(10, 80);
          case ($urandom_range(0, 3))
            0: duty = 0;
            1: duty = 20;
            2: duty = 50;
            default: duty = 85;
          endcase
        end
        phase_left--;
        resp_stall <= ($urandom_range(0, 99) < duty);
      end
    end
  end

  initial begin : req_side
    req_t        cur;
    int          i;
    int          k;
    int          sent;
    int          mode;
    int          run_len;
    int          pick;
    logic [63:0] w;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    fail_count = 0;
    burst_left = 0;
    ring_head = '0;
    ring_count = '0;
    ring_flipped = 1'b0;
    for (i = 0; i < DEPTH; i++) begin
      ring_words[i] = '0;
    end

    plan[0]  = '{FN_QUERY,      64'd0,                  8'd1,  1'b1, EMPTY_OK};
    plan[1]  = '{FN_POP_FRONT,  64'd0,                  8'd1,  1'b1, EMPTY_ERR};
    plan[2]  = '{FN_POP_BACK,   64'd0,                  8'd1,  1'b1, EMPTY_ERR};
    plan[3]  = '{FN_REVERSE,    64'd0,                  8'd1,  1'b1, EMPTY_ERR};
    plan[4]  = '{FN_SPARE_6,    ALL_ONES,               8'd1,  1'b1, EMPTY_OK};
    plan[5]  = '{FN_SPARE_7,    ALL_ONES,               8'd1,  1'b1, EMPTY_OK};
    plan[6]  = '{FN_PUSH_BACK,  ALL_ONES,               8'd1,  1'b1,
                 '{ALL_ONES, ALL_ONES, 5'd1, 1'b0, 1'b0}};
    plan[7]  = '{FN_PUSH_FRONT, 64'd0,                  8'd1,  1'b1,
                 '{64'd0, ALL_ONES, 5'd2, 1'b0, 1'b0}};
    plan[8]  = '{FN_REVERSE,    64'd0,                  8'd1,  1'b1,
                 '{ALL_ONES, 64'd0, 5'd2, 1'b0, 1'b0}};
    plan[9]  = '{FN_PUSH_FRONT, 64'h8000_0000_0000_0001, 8'd1,  1'b0, '0};
    plan[10] = '{FN_PUSH_BACK,  64'h5555_5555_5555_5555, 8'd1,  1'b0, '0};
    plan[11] = '{FN_POP_FRONT,  64'd0,                  8'd1,  1'b0, '0};
    plan[12] = '{FN_REVERSE,    64'd0,                  8'd1,  1'b0, '0};
    plan[13] = '{FN_POP_BACK,   64'd0,                  8'd1,  1'b0, '0};
    plan[14] = '{FN_QUERY,      ALL_ONES,               8'd1,  1'b0, '0};
    plan[15] = '{FN_PUSH_BACK,  64'hAAAA_AAAA_AAAA_AAAA, 8'd16, 1'b0, '0};
    plan[16] = '{FN_PUSH_FRONT, 64'h0123_4567_89AB_CDEF, 8'd1,  1'b0, '0};
    plan[17] = '{FN_REVERSE,    64'd0,                  8'd1,  1'b0, '0};
    plan[18] = '{FN_POP_FRONT,  64'd0,                  8'd17, 1'b0, '0};
    plan[19] = '{FN_POP_BACK,   64'd0,                  8'd1,  1'b1, EMPTY_ERR};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      for (k = 0; k < plan[i].reps; k++) begin
        cur.func = plan[i].func;
        cur.data_word = plan[i].word ^ 64'(k);
        issue(cur, plan[i].pinned, plan[i].want);
      end
    end

    // Runs of requests lean toward filling, draining or churning the queue, with
    // occasional runs of unbiased codes including the spare ones.
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      mode = $urandom_range(0, 9);
      run_len = $urandom_range(10, 50);
      for (k = 0; k < run_len && sent < RANDOM_REQUESTS; k++) begin
        pick = $urandom_range(0, 99);
        if (mode <= 2) begin
          cur.func = (pick < 75) ? ((pick & 1) ? FN_PUSH_BACK : FN_PUSH_FRONT) :
                     (pick < 85) ? FN_REVERSE :
                     (pick < 95) ? ((pick & 1) ? FN_POP_BACK : FN_POP_FRONT) : FN_QUERY;
        end else if (mode <= 5) begin
          cur.func = (pick < 70) ? ((pick & 1) ? FN_POP_BACK : FN_POP_FRONT) :
                     (pick < 85) ? ((pick & 1) ? FN_PUSH_BACK : FN_PUSH_FRONT) :
                     (pick < 95) ? FN_REVERSE : FN_QUERY;
        end else if (mode <= 8) begin
          cur.func = (pick < 40) ? ((pick & 1) ? FN_PUSH_BACK : FN_PUSH_FRONT) :
                     (pick < 80) ? ((pick & 1) ? FN_POP_BACK : FN_POP_FRONT) :
                     (pick < 95) ? FN_REVERSE : FN_QUERY;
        end else begin
          cur.func = FUNC_BITS'($urandom_range(0, 7));
        end
        pick = $urandom_range(0, 99);
        w = {$urandom, $urandom};
        cur.data_word = (pick < 5) ? ALL_ONES : (pick < 10) ? 64'd0 : w;
        issue(cur, 1'b0, '0);
        sent++;
      end
    end

    req_valid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/deq_pkg.sv
rtl/deq_ctrl.sv
rtl/deq_datapath.sv
rtl/double_ended_queue.sv
tb/tb_top.sv
